// ===== hw/rtl/dsrt_pkg.sv =====
package dsrt_pkg;

	localparam int MAX_MONTH = 12;
	localparam int MAX_DAY   = 31;
	localparam int MAX_HOUR  = 23;
	localparam int TAG_W     = 16;

	typedef enum logic [2:0] {
		ST_STORED    = 3'd0,
		ST_BAD_MONTH = 3'd1,
		ST_BAD_DAY   = 3'd2,
		ST_BAD_HOUR  = 3'd3,
		ST_ENTRY     = 3'd4,
		ST_EMPTY     = 3'd5
	} status_e;

	typedef struct packed {
		logic [6:0]       month_in;
		logic [6:0]       day_in;
		logic [6:0]       hour_in;
		logic [TAG_W-1:0] msg_tag;
	} in_item_t;

	typedef struct packed {
		logic [2:0]       status;
		logic             was_full;
		logic [3:0]       month_out;
		logic [4:0]       day_out;
		logic [4:0]       hour_out;
		logic [TAG_W-1:0] tag_out;
		logic             last;
	} out_item_t;

	typedef struct packed {
		logic    load_item;
		logic    insert;
		logic    pop;
		logic    load_out;
		status_e out_status;
		logic    out_full;
		logic    out_last;
	} ctl_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic last_one;
		logic bad_month;
		logic bad_day;
		logic bad_hour;
		logic day_zero;
	} ctl_stat_t;

endpackage

// ===== hw/rtl/dsrt_ctrl.sv =====
module dsrt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  dsrt_pkg::ctl_stat_t  stat,
	output dsrt_pkg::ctl_cmd_t   cmd
);
	import dsrt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EVAL = 3'b010,
		S_LIST = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   list_full_q, list_full_d;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d        = state_q;
		list_full_d    = list_full_q;
		cmd            = '0;
		cmd.out_status = ST_STORED;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_EVAL;
				end
			end
			S_EVAL: begin
				if (stat.full) begin
					list_full_d = 1'b1;
					state_d     = S_LIST;
				end else if (stat.day_zero && !stat.bad_month && !stat.bad_hour) begin
					list_full_d = 1'b0;
					state_d     = S_LIST;
				end else if (out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_last = 1'b1;
					state_d      = S_IDLE;
					if (stat.bad_month) begin
						cmd.out_status = ST_BAD_MONTH;
					end else if (stat.bad_day) begin
						cmd.out_status = ST_BAD_DAY;
					end else if (stat.bad_hour) begin
						cmd.out_status = ST_BAD_HOUR;
					end else begin
						cmd.out_status = ST_STORED;
						cmd.insert     = 1'b1;
					end
				end
			end
			S_LIST: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_full = list_full_q;
					if (stat.empty) begin
						cmd.out_status = ST_EMPTY;
						cmd.out_last   = 1'b1;
						state_d        = S_IDLE;
					end else begin
						cmd.out_status = ST_ENTRY;
						cmd.out_last   = stat.last_one;
						cmd.pop        = 1'b1;
						if (stat.last_one) begin
							state_d = S_IDLE;
						end
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			list_full_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			list_full_q <= list_full_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/dsrt_datapath.sv =====
module dsrt_datapath #(
	parameter int CAPACITY = 64,
	parameter int TAG_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dsrt_pkg::in_item_t   in_item,
	input  dsrt_pkg::ctl_cmd_t   cmd,
	output dsrt_pkg::ctl_stat_t  stat,
	output dsrt_pkg::out_item_t  out_item
);
	import dsrt_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int TW    = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

	typedef struct packed {
		logic [3:0]    month;
		logic [4:0]    day;
		logic [4:0]    hour;
		logic [TW-1:0] tag;
	} entry_t;

	in_item_t           item_q;
	out_item_t          out_q;
	logic [CNT_W-1:0]   count_q;
	entry_t             cell_q    [CAPACITY];
	entry_t             prev_cell [CAPACITY];
	entry_t             next_cell [CAPACITY];
	logic [CAPACITY-1:0] ins;
	logic [CAPACITY-1:0] ins_prev;
	entry_t             new_entry;
	logic [13:0]        new_key;

	assign new_entry.month = item_q.month_in[3:0];
	assign new_entry.day   = item_q.day_in[4:0];
	assign new_entry.hour  = item_q.hour_in[4:0];
	assign new_entry.tag   = item_q.msg_tag[TW-1:0];
	assign new_key         = {new_entry.month, new_entry.day, new_entry.hour};

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		assign ins[g] = (CNT_W'(g) >= count_q) ||
			({cell_q[g].month, cell_q[g].day, cell_q[g].hour} > new_key);
		if (g == 0) begin : g_head
			assign prev_cell[g] = new_entry;
			assign ins_prev[g]  = 1'b0;
		end else begin : g_body
			assign prev_cell[g] = cell_q[g-1];
			assign ins_prev[g]  = ins[g-1];
		end
		if (g == CAPACITY - 1) begin : g_tail
			assign next_cell[g] = cell_q[g];
		end else begin : g_mid
			assign next_cell[g] = cell_q[g+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.insert) begin
				if (ins[g] && !ins_prev[g]) begin
					cell_q[g] <= new_entry;
				end else if (ins[g]) begin
					cell_q[g] <= prev_cell[g];
				end
			end else if (cmd.pop) begin
				cell_q[g] <= next_cell[g];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.insert) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.pop) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= in_item;
		end
		if (cmd.load_out) begin
			out_q.status   <= cmd.out_status;
			out_q.was_full <= cmd.out_full;
			out_q.last     <= cmd.out_last;
			if (cmd.out_status == ST_ENTRY) begin
				out_q.month_out <= cell_q[0].month;
				out_q.day_out   <= cell_q[0].day;
				out_q.hour_out  <= cell_q[0].hour;
				out_q.tag_out   <= TAG_W'(cell_q[0].tag);
			end else begin
				out_q.month_out <= '0;
				out_q.day_out   <= '0;
				out_q.hour_out  <= '0;
				out_q.tag_out   <= '0;
			end
		end
	end

	always_comb begin
		stat.full      = (count_q == CNT_W'(CAPACITY));
		stat.empty     = (count_q == '0);
		stat.last_one  = (count_q == CNT_W'(1));
		stat.bad_month = (item_q.month_in == 7'd0) || (item_q.month_in > 7'(MAX_MONTH));
		stat.bad_day   = (item_q.day_in > 7'(MAX_DAY));
		stat.bad_hour  = (item_q.hour_in > 7'(MAX_HOUR));
		stat.day_zero  = (item_q.day_in == 7'd0);
	end

	assign out_item = out_q;

endmodule

// ===== hw/rtl/date_sorted_reminder_table.sv =====
// Sorted reminder table. Items arrive on the in channel (in_valid, in_ready,
// in_item) and results leave on the out channel (out_valid, out_ready,
// out_item), one result per beat.
// A stored or rejected item is accepted in the idle state, then checked in the
// eval state and, if valid, inserted into the cell chain, where every cell
// compares its key with the new one in the same cycle. Its single result is
// registered once the output register is free, and no new item is taken before
// that result is loaded.
// A listing (a valid item with day 0, or any item while the list is full)
// starts in the eval state and then moves one entry per cycle, while the
// receiver takes them, out of the head of the chain; an empty list gives
// one empty result.
// in_ready is high only while no item is in work.
// When the receiver stalls, the result stays in the output register and
// the chain waits; nothing is lost.
// Reset clears the entry count and the output valid. Cell contents are not
// cleared and need no clearing pass, since only entries below the count
// are ever read.
module date_sorted_reminder_table #(
	parameter int CAPACITY = 64,
	parameter int TAG_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  dsrt_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output dsrt_pkg::out_item_t out_item
);
	import dsrt_pkg::*;

	ctl_cmd_t  cmd;
	ctl_stat_t stat;

	dsrt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	dsrt_datapath #(
		.CAPACITY (CAPACITY),
		.TAG_BITS (TAG_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.cmd      (cmd),
		.stat     (stat),
		.out_item (out_item)
	);

endmodule

// ===== test/tb_date_sorted_reminder_table.sv =====
`timescale 1ns / 100ps

module tb_date_sorted_reminder_table;
	import dsrt_pkg::*;

	localparam int CAPACITY   = 64;
	localparam int ITEM_COUNT = 480;
	localparam int IDLE_LIMIT = 2000;

	typedef struct packed {
		logic [3:0]       month;
		logic [4:0]       day;
		logic [4:0]       hour;
		logic [TAG_W-1:0] tag;
	} reminder_t;

	class reminder_scoreboard;
		reminder_t entries [CAPACITY];
		int        entry_count;
		out_item_t pending_results [$];
		int        failures;

		function new();
			entry_count = 0;
			failures = 0;
		endfunction

		function string show(out_item_t r);
			return $sformatf("status=%0d full=%0b month=%0d day=%0d hour=%0d tag=%h last=%0b",
				r.status, r.was_full, r.month_out, r.day_out, r.hour_out, r.tag_out, r.last);
		endfunction

		function void push_result(status_e st, logic full, reminder_t e, logic last);
			out_item_t r;
			r.status = st;
			r.was_full = full;
			r.month_out = e.month;
			r.day_out = e.day;
			r.hour_out = e.hour;
			r.tag_out = e.tag;
			r.last = last;
			pending_results.push_back(r);
		endfunction

		function void list_entries(logic full);
			if (entry_count == 0) begin
				push_result(ST_EMPTY, full, '0, 1'b1);
			end else begin
				for (int i = 0; i < entry_count; i++)
					push_result(ST_ENTRY, full, entries[i], i == entry_count - 1);
			end
			entry_count = 0;
		endfunction

		function void note_item(in_item_t it);
			reminder_t fresh;
			int pos;
			fresh.month = it.month_in[3:0];
			fresh.day = it.day_in[4:0];
			fresh.hour = it.hour_in[4:0];
			fresh.tag = it.msg_tag;
			if (entry_count >= CAPACITY) begin
				list_entries(1'b1);
			end else if (it.month_in < 1 || it.month_in > MAX_MONTH) begin
				push_result(ST_BAD_MONTH, 1'b0, '0, 1'b1);
			end else if (it.day_in > MAX_DAY) begin
				push_result(ST_BAD_DAY, 1'b0, '0, 1'b1);
			end else if (it.hour_in > MAX_HOUR) begin
				push_result(ST_BAD_HOUR, 1'b0, '0, 1'b1);
			end else if (it.day_in == 0) begin
				list_entries(1'b0);
			end else begin
				pos = 0;
				while (pos < entry_count && {entries[pos].month, entries[pos].day,
						entries[pos].hour} <= {fresh.month, fresh.day, fresh.hour})
					pos++;
				for (int j = entry_count; j > pos; j--)
					entries[j] = entries[j - 1];
				entries[pos] = fresh;
				entry_count++;
				push_result(ST_STORED, 1'b0, '0, 1'b1);
			end
		endfunction

		function void check_beat(out_item_t got);
			out_item_t want;
			if (pending_results.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("Unexpected result beat: %s", show(got));
				return;
			end
			want = pending_results.pop_front();
			if (got.status !== want.status || got.was_full !== want.was_full ||
					got.month_out !== want.month_out || got.day_out !== want.day_out ||
					got.hour_out !== want.hour_out || got.tag_out !== want.tag_out ||
					got.last !== want.last) begin
				failures++;
				if (failures <= 10)
					$display("Result mismatch: expected %s, got %s", show(want), show(got));
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_item;

	reminder_scoreboard sb;
	int        items_sent;
	int        burst_left;
	int        idle_cycles;
	in_item_t  last_store;
	logic      have_last;

	date_sorted_reminder_table #(
		.CAPACITY(CAPACITY),
		.TAG_BITS(TAG_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_item(in_item);
			if (out_valid && out_ready)
				sb.check_beat(out_item);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_date_sorted_reminder_table failed");
			$finish;
		end
	end

	initial begin
		int run;
		int hold;
		out_ready = 1'b0;
		forever begin
			run = $urandom_range(1, 8);
			if ($urandom_range(0, 5) == 0)
				run = $urandom_range(30, 90);
			repeat (run) begin
				@(negedge clk);
				out_ready = 1'b1;
			end
			hold = $urandom_range(1, 12);
			repeat (hold) begin
				@(negedge clk);
				out_ready = 1'b0;
			end
		end
	end

	function automatic in_item_t make_item(int m, int d, int h, int tag);
		in_item_t it;
		it.month_in = 7'(m);
		it.day_in = 7'(d);
		it.hour_in = 7'(h);
		it.msg_tag = TAG_W'(tag);
		return it;
	endfunction

	function automatic in_item_t store_item();
		in_item_t it;
		if (have_last && $urandom_range(0, 3) == 0) begin
			it = last_store;
		end else begin
			it.month_in = 7'($urandom_range(1, 12));
			it.day_in = 7'($urandom_range(1, 31));
			it.hour_in = 7'($urandom_range(0, 23));
		end
		it.msg_tag = TAG_W'($urandom);
		last_store = it;
		have_last = 1'b1;
		return it;
	endfunction

	function automatic in_item_t noise_item();
		return make_item($urandom_range(0, 127), $urandom_range(0, 127),
			$urandom_range(0, 127), $urandom);
	endfunction

	function automatic in_item_t error_item();
		in_item_t it;
		it = noise_item();
		case ($urandom_range(0, 2))
			0: begin
				it.month_in = ($urandom_range(0, 3) == 0) ? 7'd0 : 7'($urandom_range(13, 127));
			end
			1: begin
				it.month_in = 7'($urandom_range(1, 12));
				it.day_in = 7'($urandom_range(32, 127));
			end
			default: begin
				it.month_in = 7'($urandom_range(1, 12));
				it.day_in = 7'($urandom_range(0, 31));
				it.hour_in = 7'($urandom_range(24, 127));
			end
		endcase
		return it;
	endfunction

	function automatic in_item_t mixed_item();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 65)
			return store_item();
		else if (pick < 75)
			return make_item($urandom_range(1, 12), 0, $urandom_range(0, 23), $urandom);
		else if (pick < 90)
			return error_item();
		return noise_item();
	endfunction

	task automatic send_item(input in_item_t it);
		in_item = it;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_paced(input in_item_t it);
		send_item(it);
		items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 15))
				@(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 10);
		end
	endtask

	task automatic drain_results();
		in_valid = 1'b0;
		do
			@(negedge clk);
		while (sb.pending_results.size() != 0);
	endtask

	initial begin
		int round;
		sb = new();
		items_sent = 0;
		burst_left = 12;
		have_last = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_paced(make_item(5, 0, 10, 16'h1234));
		send_paced(make_item(0, 5, 5, 16'h0001));
		send_paced(make_item(13, 5, 5, 16'h0002));
		send_paced(make_item(127, 127, 127, 16'hffff));
		send_paced(make_item(12, 32, 0, 16'h0003));
		send_paced(make_item(1, 127, 0, 16'h0004));
		send_paced(make_item(6, 31, 24, 16'h0005));
		send_paced(make_item(6, 15, 127, 16'h0006));
		send_paced(make_item(12, 31, 23, 16'hffff));
		send_paced(make_item(1, 1, 0, 16'h0000));
		send_paced(make_item(6, 15, 12, 16'haaaa));
		send_paced(make_item(6, 15, 12, 16'h5555));
		send_paced(make_item(6, 15, 11, 16'h1111));
		send_paced(make_item(6, 14, 12, 16'h2222));
		send_paced(make_item(7, 1, 0, 16'h3333));
		send_paced(make_item(6, 15, 12, 16'h0f0f));
		send_paced(make_item(3, 0, 99, 16'h4444));
		send_paced(make_item(3, 0, 23, 16'h5a5a));
		send_paced(make_item(2, 0, 0, 16'ha5a5));
		send_paced(make_item(12, 31, 23, 16'hffff));
		send_paced(make_item(4, 0, 5, 16'h6666));
		drain_results();

		round = 0;
		while (items_sent < ITEM_COUNT) begin
			if (round % 4 == 2)
				drain_results();
			if (round == 0 || $urandom_range(0, 5) == 0) begin
				while (sb.entry_count < CAPACITY)
					send_paced(($urandom_range(0, 9) == 0) ? error_item() : store_item());
				send_paced(noise_item());
			end else begin
				repeat (20)
					send_paced(mixed_item());
			end
			round++;
		end

		in_valid = 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (sb.failures == 0 && sb.pending_results.size() == 0)
			$display("tb_date_sorted_reminder_table passed");
		else
			$display("tb_date_sorted_reminder_table failed");
		$finish;
	end

endmodule
